@@ rtl/leb_pkg.sv @@
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants for the line edit buffer
// Beat payload structs, mode and result codes, line store sizing.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LINE_LW    = $clog2(LINE_DEPTH + 1);

    localparam logic [LINE_LW-1:0] LINE_FULL    = LINE_LW'(LINE_DEPTH);
    localparam logic [LINE_LW-1:0] LINE_PRT_MAX = LINE_LW'(LINE_DEPTH - 1);

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_PRINT_LO  = 8'd32;
    localparam logic [7:0] CH_PRINT_HI  = 8'd126;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_CANONICAL = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ECHO      = 2'd1;

    typedef enum logic [1:0] {
        MODE_CHAR  = 2'd0,
        MODE_FETCH = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_BUSY  = 2'd3
    } t_kind;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] char_in;
        logic       reader_final;
    } t_leb_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_leb_out;

    // result decided at accept; byte comes from the store when use_ram is set
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
        logic       use_ram;
    } t_leb_stage;

    typedef struct packed {
        logic               wr_en;
        logic [LINE_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [LINE_AW-1:0] rd_addr;
    } t_leb_ram_req;

endpackage

@@ rtl/leb_ram.sv @@
// ----------------------------------------------------------------------------
// leb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/leb_ctrl.sv @@
// ----------------------------------------------------------------------------
// leb_ctrl: line editing control
// Classifies each accepted beat, updates line state and registers, drives
// the line store and holds the decided result for the output stage.
// ----------------------------------------------------------------------------
module leb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  leb_pkg::t_leb_in      i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_cfg_valid,
    input  logic [leb_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic                  i_out_free,
    output leb_pkg::t_leb_stage   o_stage,
    output leb_pkg::t_leb_ram_req o_ram
);
    import leb_pkg::*;

    logic               r_canon, r_echo;
    logic [LINE_LW-1:0] r_len, n_len;
    logic               r_complete, n_complete;
    logic [LINE_LW-1:0] r_rdpos, n_rdpos;
    t_leb_stage         r_stage, n_stage;

    logic               advance;
    logic               accept;
    logic [LINE_LW-1:0] rd_next;
    logic               printable;

    assign advance    = !r_stage.valid || i_out_free;
    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;
    assign rd_next    = r_rdpos + LINE_LW'(1);
    assign printable  = (i_in_data.char_in >= CH_PRINT_LO) &&
                        (i_in_data.char_in <= CH_PRINT_HI);

    always_comb begin
        n_len      = r_len;
        n_complete = r_complete;
        n_rdpos    = r_rdpos;
        n_stage    = '0;
        o_ram.wr_en   = 1'b0;
        o_ram.wr_addr = r_len[LINE_AW-1:0];
        o_ram.wr_data = i_in_data.char_in;
        o_ram.rd_en   = 1'b0;
        o_ram.rd_addr = r_rdpos[LINE_AW-1:0];
        if (accept) begin
            case (i_in_data.mode)
                MODE_CLEAR: begin
                    n_len      = '0;
                    n_complete = 1'b0;
                    n_rdpos    = '0;
                end
                MODE_FETCH: begin
                    if (!r_canon) begin
                        n_stage.valid = 1'b1;
                        n_stage.kind  = KIND_EMPTY;
                    end else if (!r_complete || r_rdpos >= r_len) begin
                        if (r_complete) begin
                            n_len      = '0;
                            n_complete = 1'b0;
                            n_rdpos    = '0;
                        end
                        n_stage.valid = 1'b1;
                        n_stage.kind  = KIND_EMPTY;
                    end else begin
                        o_ram.rd_en     = 1'b1;
                        n_stage.valid   = 1'b1;
                        n_stage.kind    = KIND_DATA;
                        n_stage.use_ram = 1'b1;
                        n_stage.last    = (rd_next >= r_len) || i_in_data.reader_final;
                        n_rdpos         = rd_next;
                        if (n_stage.last) begin
                            n_len      = '0;
                            n_complete = 1'b0;
                            n_rdpos    = '0;
                        end
                    end
                end
                MODE_CHAR: begin
                    if (!r_canon) begin
                        n_stage.valid    = 1'b1;
                        n_stage.kind     = KIND_DATA;
                        n_stage.out_byte = i_in_data.char_in;
                        n_stage.last     = 1'b1;
                    end else if (r_complete) begin
                        n_stage.valid = 1'b1;
                        n_stage.kind  = KIND_BUSY;
                    end else if (i_in_data.char_in == CH_BACKSPACE) begin
                        if (r_len != '0) begin
                            n_len            = r_len - LINE_LW'(1);
                            n_stage.valid    = r_echo;
                            n_stage.kind     = KIND_ECHO;
                            n_stage.out_byte = CH_BACKSPACE;
                        end
                    end else if (i_in_data.char_in == CH_NEWLINE) begin
                        if (r_len < LINE_FULL) begin
                            o_ram.wr_en = 1'b1;
                            n_len       = r_len + LINE_LW'(1);
                        end
                        n_complete       = 1'b1;
                        n_rdpos          = '0;
                        n_stage.valid    = r_echo;
                        n_stage.kind     = KIND_ECHO;
                        n_stage.out_byte = CH_NEWLINE;
                    end else if (printable && r_len < LINE_PRT_MAX) begin
                        o_ram.wr_en      = 1'b1;
                        n_len            = r_len + LINE_LW'(1);
                        n_stage.valid    = r_echo;
                        n_stage.kind     = KIND_ECHO;
                        n_stage.out_byte = i_in_data.char_in;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon       <= 1'b1;
            r_echo        <= 1'b1;
            r_len         <= '0;
            r_complete    <= 1'b0;
            r_rdpos       <= '0;
            r_stage.valid <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_complete <= n_complete;
            r_rdpos    <= n_rdpos;
            if (advance) begin
                r_stage <= n_stage;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_CANONICAL) begin
                    r_canon <= i_cfg_data;
                end else if (i_cfg_index == CFG_ECHO) begin
                    r_echo <= i_cfg_data;
                end
            end
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/leb_out.sv @@
// ----------------------------------------------------------------------------
// leb_out: result register
// Merges store read data into the pending result and holds the output beat.
// ----------------------------------------------------------------------------
module leb_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  leb_pkg::t_leb_stage i_stage,
    input  logic [7:0]          i_rd_data,
    input  logic                i_out_stall,
    output logic                o_out_free,
    output logic                o_out_valid,
    output leb_pkg::t_leb_out   o_out_data
);
    import leb_pkg::*;

    logic     r_valid;
    t_leb_out r_data, n_data;

    assign o_out_free = !r_valid || !i_out_stall;

    always_comb begin
        n_data.kind     = i_stage.kind;
        n_data.out_byte = i_stage.use_ram ? i_rd_data : i_stage.out_byte;
        n_data.last     = i_stage.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_out_free) begin
            r_valid <= i_stage.valid;
        end
        if (o_out_free) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ rtl/line_edit_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// line_edit_buffer_unit: canonical-mode terminal line editor
// Edits received characters into a line store, echoes them, and hands the
// completed line to the reader a byte per fetch; raw mode passes through.
// ----------------------------------------------------------------------------
//  channel   signals                                 dir   beat
//  in        i_in_valid, o_in_stall, i_in_data       in    mode, char, final
//  out       o_out_valid, i_out_stall, o_out_data    out   kind, byte, last
//  cfg       i_cfg_valid, o_cfg_ready, i_cfg_index,  in    register write
//            i_cfg_data
//
// One beat accepted per cycle while out stall does not back up; a result passes
// through the stage register and line store read, then the result register.
// Line state updates at accept and registers at a cfg write, so the next beat sees them.
// Reset restores canonical and echo on and an empty line; store needs no clear.
// out stall holds the result register and backs up into in stall.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  leb_pkg::t_leb_in           i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output leb_pkg::t_leb_out          o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [leb_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic                       i_cfg_data
);
    import leb_pkg::*;

    t_leb_stage   stage;
    t_leb_ram_req ram_req;
    logic [7:0]   rd_data;
    logic         out_free;

    assign o_cfg_ready = 1'b1;

    leb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (out_free),
        .o_stage     (stage),
        .o_ram       (ram_req)
    );

    leb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    leb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/tb_line_edit_buffer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_edit_buffer_unit: self-checking bench for the line edit buffer
// Drives character, fetch, clear and undefined beats with random gaps and
// output stalls, predicts every result from a line-state shadow, and checks
// each result beat field by field. Runs canonical and raw mode with echo on and
// off, and also writes to the unused register indexes.
// ----------------------------------------------------------------------------
module tb_line_edit_buffer_unit;
    import leb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [CFG_IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_SPARE_B = 2'd3;

    // shadow of the line discipline plus the queue of results it owes
    class line_checker;
        logic [7:0]         shadow_bytes [LINE_DEPTH];
        logic [LINE_LW-1:0] shadow_count;
        logic               line_done;
        logic [LINE_LW-1:0] rd_pos;
        logic               canon_on;
        logic               echo_on;
        t_leb_out           pending_results[$];
        int                 errors;
        int                 beats;
        int                 checked;
        int                 kind_seen[4];

        function new();
            canon_on = 1'b1;
            echo_on  = 1'b1;
            errors   = 0;
            beats    = 0;
            checked  = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            clear_line();
        endfunction

        function void clear_line();
            shadow_count = '0;
            line_done    = 1'b0;
            rd_pos       = '0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic val);
            if (idx == CFG_CANONICAL) begin
                canon_on = val;
            end else if (idx == CFG_ECHO) begin
                echo_on = val;
            end
        endfunction

        function bit echo_byte(logic [7:0] c, output t_leb_out r);
            r.kind     = KIND_ECHO;
            r.out_byte = c;
            r.last     = 1'b0;
            return echo_on;
        endfunction

        function bit fetch_line_byte(logic fin, output t_leb_out r);
            r.kind     = KIND_EMPTY;
            r.out_byte = 8'd0;
            r.last     = 1'b0;
            if (!line_done || rd_pos >= shadow_count) begin
                if (line_done) clear_line();
                return 1'b1;
            end
            r.kind     = KIND_DATA;
            r.out_byte = shadow_bytes[rd_pos[LINE_AW-1:0]];
            rd_pos++;
            r.last = (rd_pos >= shadow_count) || fin;
            if (r.last) clear_line();
            return 1'b1;
        endfunction

        function bit predict_line_result(t_leb_in b, output t_leb_out r);
            r.kind     = KIND_EMPTY;
            r.out_byte = 8'd0;
            r.last     = 1'b0;
            case (b.mode)
                MODE_CLEAR: begin
                    clear_line();
                    return 1'b0;
                end
                MODE_NONE: return 1'b0;
                default: ;
            endcase
            if (!canon_on) begin
                if (b.mode == MODE_CHAR) begin
                    r.kind     = KIND_DATA;
                    r.out_byte = b.char_in;
                    r.last     = 1'b1;
                end
                return 1'b1;
            end
            if (b.mode == MODE_FETCH) return fetch_line_byte(b.reader_final, r);
            if (line_done) begin
                r.kind = KIND_BUSY;
                return 1'b1;
            end
            if (b.char_in == CH_BACKSPACE) begin
                if (shadow_count == 0) return 1'b0;
                shadow_count--;
                return echo_byte(b.char_in, r);
            end
            if (b.char_in == CH_NEWLINE) begin
                // newline still lands when printables have filled all but one slot
                if (shadow_count < LINE_FULL) begin
                    shadow_bytes[shadow_count[LINE_AW-1:0]] = CH_NEWLINE;
                    shadow_count++;
                end
                line_done = 1'b1;
                rd_pos    = '0;
                return echo_byte(b.char_in, r);
            end
            if (b.char_in >= CH_PRINT_LO && b.char_in <= CH_PRINT_HI &&
                shadow_count < LINE_PRT_MAX) begin
                shadow_bytes[shadow_count[LINE_AW-1:0]] = b.char_in;
                shadow_count++;
                return echo_byte(b.char_in, r);
            end
            return 1'b0;
        endfunction

        function void take_beat(t_leb_in b);
            t_leb_out r;
            beats++;
            if (predict_line_result(b, r)) pending_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task match_result(t_leb_out got);
            t_leb_out want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
                                 got.kind, got.out_byte, got.last));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            kind_seen[got.kind]++;
            if (got.kind !== want.kind)
                report($sformatf("result %0d kind %0d, want %0d", checked, got.kind, want.kind));
            if (got.out_byte !== want.out_byte)
                report($sformatf("result %0d byte %02h, want %02h", checked, got.out_byte,
                                 want.out_byte));
            if (got.last !== want.last)
                report($sformatf("result %0d last %0b, want %0b", checked, got.last, want.last));
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_leb_in             i_in_data   = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_leb_out            o_out_data;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic                i_cfg_data  = 1'b0;

    line_checker sb = new();
    bit          calm = 1'b0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          run_left = 0;

    line_edit_buffer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    endfunction

    // control or high byte that is neither backspace nor newline
    function automatic logic [7:0] rand_other();
        logic [7:0] c;
        do begin
            c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                           : 8'($urandom_range(127, 255));
        end while (c == CH_BACKSPACE || c == CH_NEWLINE);
        return c;
    endfunction

    // result side: check accepted beats, then pick the stall for the next edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) sb.match_result(o_out_data);
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (run_left != 0) begin
                run_left--;
                i_out_stall <= 1'b0;
            end else begin
                run_left   = calm ? 16 : $urandom_range(0, 6);
                stall_left = pick_gap();
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no beat moved for %0d cycles", $time, idle_cycles);
                $display("tb_line_edit_buffer_unit: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // valid is left high after a beat; it only drops for a gap or a pause
    task automatic send_beat(t_mode m, logic [7:0] c, logic fin);
        t_leb_in b;
        int      gap;
        b.mode         = m;
        b.char_in      = c;
        b.reader_final = fin;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_beat(b);
    endtask

    task automatic type_char(logic [7:0] c);
        send_beat(MODE_CHAR, c, 1'($urandom));
    endtask

    task automatic fetch(logic fin);
        send_beat(MODE_FETCH, 8'($urandom), fin);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic val);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    // read out the waiting line; stray characters in between must come back busy
    task automatic drain_line(bit whole);
        while (sb.canon_on && sb.line_done) begin
            if (!whole && $urandom_range(0, 9) == 0) type_char(8'($urandom));
            else fetch(whole ? 1'b0 : ($urandom_range(0, 6) == 0));
        end
    endtask

    task automatic type_line();
        int n;
        int r;
        n = $urandom_range(0, 14);
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 15) type_char(rand_printable());
            else if (r < 18) type_char(CH_BACKSPACE);
            else type_char(rand_other());
        end
        if ($urandom_range(0, 9) == 0) begin
            send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
            return;
        end
        type_char(CH_NEWLINE);
        repeat ($urandom_range(0, 2)) type_char(8'($urandom));
        drain_line(1'b0);
        if ($urandom_range(0, 3) == 0) fetch(1'($urandom));
    endtask

    // types up to or past the printable limit; past it the tail is dropped and newline takes the last slot
    task automatic long_line();
        repeat ($urandom_range(253, 262)) type_char(rand_printable());
        type_char(rand_other());
        type_char(CH_NEWLINE);
        drain_line(1'b1);
    endtask

    task automatic run_random(int budget);
        int stop;
        stop = sb.beats + budget;
        while (sb.beats < stop) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: type_line();
                7, 8: begin
                    repeat ($urandom_range(1, 6))
                        send_beat(t_mode'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                end
                default: begin
                    repeat ($urandom_range(0, 4)) type_char(rand_printable());
                    if ($urandom_range(0, 1) == 0) fetch(1'($urandom));
                    else send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
                end
            endcase
        end
        calm = 1'b0;
    endtask

    task automatic run_directed();
        fetch(1'b0);                        // no line yet
        type_char(CH_BACKSPACE);            // empty line, silent
        type_char(8'd31);
        type_char(8'd127);
        type_char(8'd255);
        type_char(8'd0);
        type_char(CH_PRINT_LO);
        type_char(CH_PRINT_HI);
        type_char(8'h61);
        type_char(CH_BACKSPACE);
        send_beat(MODE_NONE, 8'hFF, 1'b1);  // undefined mode, ignored
        type_char(CH_NEWLINE);
        type_char(8'h78);                   // line waiting: busy
        type_char(CH_BACKSPACE);
        fetch(1'b0);
        fetch(1'b1);                        // reader stops early
        fetch(1'b0);
        type_char(8'h71);
        send_beat(MODE_CLEAR, 8'h00, 1'b0);
        type_char(CH_NEWLINE);
        fetch(1'b0);
        type_char(8'h7A);
        type_char(CH_NEWLINE);
        fetch(1'b1);
        fetch(1'b0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        long_line();
        run_random(350);

        cfg_write(CFG_ECHO, 1'b0);
        run_random(200);

        cfg_write(CFG_CANONICAL, 1'b0);
        cfg_write(CFG_ECHO, 1'b1);
        run_random(150);

        cfg_write(CFG_ECHO, 1'b0);
        run_random(100);

        cfg_write(CFG_CANONICAL, 1'b1);
        cfg_write(CFG_ECHO, 1'b1);
        cfg_write(CFG_SPARE_A, 1'b0);       // unused indexes must not touch anything
        cfg_write(CFG_SPARE_B, 1'b0);
        run_random(100);

        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        foreach (sb.pending_results[k])
            sb.report($sformatf("result never arrived: kind %0d byte %02h",
                                sb.pending_results[k].kind, sb.pending_results[k].out_byte));

        $display("summary: %0d beats in, %0d results checked, canonical and raw, echo on/off",
                 sb.beats, sb.checked);
        $display("summary: echo %0d, data %0d, no line %0d, busy %0d",
                 sb.kind_seen[KIND_ECHO], sb.kind_seen[KIND_DATA],
                 sb.kind_seen[KIND_EMPTY], sb.kind_seen[KIND_BUSY]);
        if (sb.errors == 0) begin
            $display("tb_line_edit_buffer_unit: done, clean");
        end else begin
            $display("tb_line_edit_buffer_unit: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/leb_pkg.sv
rtl/leb_ram.sv
rtl/leb_ctrl.sv
rtl/leb_out.sv
rtl/line_edit_buffer_unit.sv
tb/tb_line_edit_buffer_unit.sv
